FILE: hdl/cenum_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cenum_pkg
// Shared constants and control/status types of the combination enumerator.
// ---------------------------------------------------------------------------
package cenum_pkg;

  localparam int MAX_SET    = 64;
  localparam int MAX_CHOOSE = 16;

  localparam int SET_W    = 7;   // set_size register
  localparam int CHOOSE_W = 5;   // choose_size register
  localparam int POS_W    = 7;   // stored position
  localparam int ELEM_W   = 6;   // emitted element
  localparam int IDX_W    = $clog2(MAX_CHOOSE);
  localparam int LIM_W    = SET_W + 1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register select, taken from paddr[2]
  localparam logic REG_SET_SIZE    = 1'b0;
  localparam logic REG_CHOOSE_SIZE = 1'b1;

  localparam logic [SET_W-1:0]    SET_SIZE_RST    = 7'd4;
  localparam logic [CHOOSE_W-1:0] CHOOSE_SIZE_RST = 5'd2;

  typedef struct packed {
    logic store_init;  // load 0,1,2,.. into every position
    logic idx_top;     // index := k-1
    logic idx_clear;   // index := 0
    logic idx_dec;
    logic idx_inc;
    logic pivot_cap;   // remember the position that gets incremented
    logic adv_we;      // write back the advanced position
    logic out_load;    // load the output word
    logic out_exh;     // output word is the exhaustion word
    logic out_final;   // combination is the last one
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_ok;      // m and k describe a non-empty sequence
    logic hit;         // position at index is below its limit
    logic idx_zero;
    logic idx_top;     // index is k-1
  } dp_status_t;

endpackage

FILE: hdl/combination_enumerator_core.sv
`timescale 1ns / 1ps
// A request is taken in the idle state, the pivot scan compares one position
// per cycle, then k words follow at one per cycle unless out_stall_i holds them.
// A new request is taken only after the last word of the previous one is loaded;
// an exhaustion request emits a single exhaustion word.
// Reset: set_size 4, choose_size 2, sequence marked exhausted until a restart.
// ---------------------------------------------------------------------------
// combination_enumerator_core
// Lexicographic k-of-m combination generator with an APB register port.
// ---------------------------------------------------------------------------
module combination_enumerator_core
  import cenum_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ELEM_W-1:0]   element_value_o,
  output logic                last_in_combination_o,
  output logic                final_combination_o,
  output logic                exhausted_o
);

  logic [SET_W-1:0]    set_size_q;
  logic [CHOOSE_W-1:0] choose_size_q;
  logic                wr_en;
  ctrl_cmd_t           cmd;
  dp_status_t          sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= SET_SIZE_RST;
      choose_size_q <= CHOOSE_SIZE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SET_SIZE:    set_size_q    <= pwdata[SET_W-1:0];
        REG_CHOOSE_SIZE: choose_size_q <= pwdata[CHOOSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SET_SIZE:    prdata = APB_DW'(set_size_q);
      REG_CHOOSE_SIZE: prdata = APB_DW'(choose_size_q);
      default:         prdata = '0;
    endcase
  end

  cenum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cenum_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .set_size_i            (set_size_q),
    .choose_size_i         (choose_size_q),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .element_value_o       (element_value_o),
    .last_in_combination_o (last_in_combination_o),
    .final_combination_o   (final_combination_o),
    .exhausted_o           (exhausted_o)
  );

endmodule

FILE: hdl/cenum_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cenum_ctrl
// Request sequencer: accepts a request, scans for the pivot position, then
// emits the combination one word at a time or emits the exhaustion word.
// ---------------------------------------------------------------------------
module cenum_ctrl
  import cenum_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_EXH  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       start;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign start       = sts_i.cfg_ok && (restart_i || !done_q);

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (start) begin
            cmd_o.store_init = restart_i;
            cmd_o.idx_top    = 1'b1;
            done_d           = 1'b0;
            state_d          = ST_SCAN;
          end else begin
            done_d  = 1'b1;
            state_d = ST_EXH;
          end
        end
      end
      ST_SCAN: begin
        priority if (sts_i.hit) begin
          cmd_o.pivot_cap = 1'b1;
          cmd_o.idx_clear = 1'b1;
          last_d          = 1'b0;
          state_d         = ST_EMIT;
        end else if (sts_i.idx_zero) begin
          // nothing left to raise: this is the last combination
          cmd_o.idx_clear = 1'b1;
          last_d          = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.idx_dec = 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_final = last_q;
          cmd_o.adv_we    = !last_q;
          out_valid_d     = 1'b1;
          if (sts_i.idx_top) begin
            done_d  = last_q;
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_exh  = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b1;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/cenum_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cenum_dp
// Position store, index counter, limit compare, advance logic and output
// word register.
// ---------------------------------------------------------------------------
module cenum_dp
  import cenum_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SET_W-1:0]    set_size_i,
  input  logic [CHOOSE_W-1:0] choose_size_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          sts_o,
  output logic [ELEM_W-1:0]   element_value_o,
  output logic                last_in_combination_o,
  output logic                final_combination_o,
  output logic                exhausted_o
);

  logic [POS_W-1:0]    store_q [MAX_CHOOSE];
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    pivot_q;
  logic [POS_W-1:0]    prev_q;
  logic [POS_W-1:0]    rd_pos;
  logic [POS_W-1:0]    new_pos;
  logic [CHOOSE_W-1:0] k_m1;
  logic [LIM_W-1:0]    limit;
  logic [ELEM_W-1:0]   elem_q;
  logic                lic_q, fin_q, exh_q;

  assign rd_pos = store_q[idx_q];
  assign k_m1   = choose_size_i - CHOOSE_W'(1);
  // position j may reach m-k+j
  assign limit  = {1'b0, set_size_i} - LIM_W'(choose_size_i) + LIM_W'(idx_q);

  assign sts_o.cfg_ok   = (set_size_i != '0) && (set_size_i <= SET_W'(MAX_SET))
                       && (choose_size_i != '0)
                       && (choose_size_i <= CHOOSE_W'(MAX_CHOOSE))
                       && (SET_W'(choose_size_i) <= set_size_i);
  assign sts_o.hit      = LIM_W'(rd_pos) < limit;
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.idx_top  = (idx_q == k_m1[IDX_W-1:0]);

  // pivot gets +1, positions above it follow on consecutively
  always_comb begin
    priority if (idx_q == pivot_q) begin
      new_pos = rd_pos + POS_W'(1);
    end else if (idx_q > pivot_q) begin
      new_pos = prev_q + POS_W'(1);
    end else begin
      new_pos = rd_pos;
    end
  end

  always_comb begin
    priority if (cmd_i.idx_top) begin
      idx_d = k_m1[IDX_W-1:0];
    end else if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IDX_W'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_init) begin
      for (int i = 0; i < MAX_CHOOSE; i++) begin
        store_q[i] <= POS_W'(i);
      end
    end else if (cmd_i.adv_we) begin
      store_q[idx_q] <= new_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pivot_cap) begin
      pivot_q <= idx_q;
    end
    if (cmd_i.out_load) begin
      prev_q <= new_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_exh) begin
        elem_q <= '0;
        lic_q  <= 1'b1;
        fin_q  <= 1'b0;
        exh_q  <= 1'b1;
      end else begin
        elem_q <= rd_pos[ELEM_W-1:0];
        lic_q  <= sts_o.idx_top;
        fin_q  <= cmd_i.out_final;
        exh_q  <= 1'b0;
      end
    end
  end

  assign element_value_o       = elem_q;
  assign last_in_combination_o = lic_q;
  assign final_combination_o   = fin_q;
  assign exhausted_o           = exh_q;

endmodule

FILE: hdl/cenum_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cenum_checker
// Port-level checks of the combination enumerator, bound to the top level.
// ---------------------------------------------------------------------------
module cenum_checker
  import cenum_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ELEM_W-1:0] element_value_o,
  input logic              last_in_combination_o,
  input logic              final_combination_o,
  input logic              exhausted_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_value_o)
      && $stable(last_in_combination_o) && $stable(final_combination_o)
      && $stable(exhausted_o))
    else $error("output word changed while stalled");

  // exhaustion word is a lone zero marked last
  a_exh_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> last_in_combination_o
      && !final_combination_o && (element_value_o == '0))
    else $error("malformed exhaustion word");

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request not held busy");

  // no new request while a combination is only partly shown
  a_busy_mid_comb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_in_combination_o |-> in_stall_o)
    else $error("request taken mid combination");

endmodule

bind combination_enumerator_core cenum_checker u_cenum_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .element_value_o       (element_value_o),
  .last_in_combination_o (last_in_combination_o),
  .final_combination_o   (final_combination_o),
  .exhausted_o           (exhausted_o)
);
